@@ rtl/bounded_lifo_stack_engine_top_macros.svh @@
// Assertion helpers for the stack engine.
`ifndef BOUNDED_LIFO_STACK_ENGINE_TOP_MACROS_SVH
`define BOUNDED_LIFO_STACK_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BLSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/blse_pkg.sv @@
package blse_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] KIND_PUSH    = 3'd0;
   localparam logic [2:0] KIND_POP     = 3'd1;
   localparam logic [2:0] KIND_PEEK    = 3'd2;
   localparam logic [2:0] KIND_CLEAR   = 3'd3;
   localparam logic [2:0] KIND_REVERSE = 3'd4;

   localparam logic signed [31:0] ERR_VALUE = -32'sd1;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic               error;
      logic               is_empty;
      logic               is_full;
      logic [4:0]         count;
   } rsp_type;

endpackage

@@ rtl/bounded_lifo_stack_engine_top.sv @@
// Channel   Handshake             Word
// --------  --------------------  -----------------------------------------
// request   req_valid/req_stall   req_word: kind, push_value
// response  rsp_valid/rsp_stall   rsp_word: out_value, error, flags, count
//
// Push, clear, no-op and every erroring word answer from idle; pop and peek
// go through S_RD_TOP, as the read port of the entry memory is registered.
// Reverse swaps floor(count / 2) pairs: one shared read port and one
// write port swap a pair in three steps (read high, write low, write high).
// Reset is synchronous; it empties the stack and drops any pending response.
// A stalled response is held in the output register; the next request is still
// taken, and its response parks in a hold register until the output frees up.

`include "bounded_lifo_stack_engine_top_macros.svh"

module bounded_lifo_stack_engine_top #(
   parameter int STACK_DEPTH = blse_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  blse_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output blse_pkg::rsp_type rsp_word
);
   import blse_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_RD_TOP   = 6'b000010,
      S_SWAP_RHI = 6'b000100,
      S_SWAP_WLO = 6'b001000,
      S_SWAP_WHI = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   // entry memory: one write port, one registered read port
   logic signed [31:0] mem [STACK_DEPTH];
   logic signed [31:0] rd_data_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      lo_ff, lo_in;
   logic [AW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      lo_next, hi_next;
   logic signed [31:0] tmp_ff, tmp_in;
   rsp_type            hold_ff, hold_in;
   rsp_type            rsp_word_ff, rsp_word_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_acc;
   logic               rsp_free;
   logic               is_full_now;
   logic               is_empty_now;
   logic               res_vld;
   logic signed [31:0] res_value;
   logic               res_err;
   rsp_type            res_word;

   assign req_stall    = (state_ff != S_IDLE);
   assign req_acc      = req_valid && (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign is_full_now  = (cnt_ff == CW'(STACK_DEPTH));
   assign is_empty_now = (cnt_ff == '0);
   assign lo_next      = lo_ff + 1'b1;
   assign hi_next      = hi_ff - 1'b1;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      tmp_in    = tmp_ff;
      hold_in   = hold_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = req_word.push_value;
      res_vld   = 1'b0;
      res_value = '0;
      res_err   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_word.kind) inside
                  KIND_PUSH: begin
                     res_vld = 1'b1;
                     if (is_full_now) begin
                        res_err   = 1'b1;
                        res_value = ERR_VALUE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(cnt_ff);
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  KIND_POP, KIND_PEEK: begin
                     if (is_empty_now) begin
                        res_vld   = 1'b1;
                        res_err   = 1'b1;
                        res_value = ERR_VALUE;
                     end else begin
                        // fetch the top; pop drops it from the count now
                        rd_en    = 1'b1;
                        rd_addr  = AW'(cnt_ff - 1'b1);
                        state_in = S_RD_TOP;
                        if (req_word.kind == KIND_POP) begin
                           cnt_in = cnt_ff - 1'b1;
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     res_vld = 1'b1;
                     cnt_in  = '0;
                  end
                  KIND_REVERSE: begin
                     if (cnt_ff > CW'(1)) begin
                        // read the bottom entry, start swapping from both ends
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        lo_in    = '0;
                        hi_in    = AW'(cnt_ff - 1'b1);
                        state_in = S_SWAP_RHI;
                     end else begin
                        res_vld = 1'b1;
                     end
                  end
                  default: begin
                     res_vld = 1'b1;
                  end
               endcase
            end
         end
         S_RD_TOP: begin
            res_vld   = 1'b1;
            res_value = rd_data_ff;
         end
         S_SWAP_RHI: begin
            rd_en    = 1'b1;
            rd_addr  = hi_ff;
            tmp_in   = rd_data_ff;
            state_in = S_SWAP_WLO;
         end
         S_SWAP_WLO: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data_ff;
            state_in = S_SWAP_WHI;
         end
         S_SWAP_WHI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
            lo_in   = lo_next;
            hi_in   = hi_next;
            // next low address never equals the high one being written
            if (lo_next < hi_next) begin
               rd_en    = 1'b1;
               rd_addr  = lo_next;
               state_in = S_SWAP_RHI;
            end else begin
               res_vld = 1'b1;
            end
         end
         S_DONE: begin
            res_vld = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_DONE) begin
         res_word = hold_ff;
      end else begin
         res_word.out_value = res_value;
         res_word.error     = res_err;
         res_word.is_empty  = (cnt_in == '0);
         res_word.is_full   = (cnt_in == CW'(STACK_DEPTH));
         res_word.count     = 5'(cnt_in);
      end

      // deliver to the output register, or park until it frees up
      if (res_vld) begin
         if (rsp_free) begin
            state_in = S_IDLE;
         end else begin
            hold_in  = res_word;
            state_in = S_DONE;
         end
      end

      rsp_valid_in = rsp_free ? res_vld : rsp_valid_ff;
      rsp_word_in  = (rsp_free && res_vld) ? res_word : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tmp_ff      <= tmp_in;
      hold_ff     <= hold_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // count stays within the depth
   `BLSE_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(STACK_DEPTH), "count over depth")
   // a good push grows the stack by one
   `BLSE_ASSERT_NEXT(a_push_grow, clock, reset, req_acc && req_word.kind == KIND_PUSH && !is_full_now, cnt_ff == $past(cnt_ff) + 1'b1, "push did not grow count")
   // swaps only run on a proper pair
   `BLSE_ASSERT_NOW(a_swap_pair, clock, reset, state_ff == S_SWAP_WLO || state_ff == S_SWAP_WHI, lo_ff < hi_ff, "swap pair out of order")
   // a parked response implies the output register is occupied
   `BLSE_ASSERT_NOW(a_hold_busy, clock, reset, state_ff == S_DONE, rsp_valid_ff, "hold without busy output")

endmodule

@@ dv/bounded_lifo_stack_engine_top_tb.sv @@
`timescale 1ns / 100ps

module bounded_lifo_stack_engine_top_tb;
   import blse_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;

   // Kind codes the block leaves undecoded; they must act as a no-op.
   localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
   localparam logic [2:0] KIND_SPARE_MID = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

   // Watchdog limit. The slowest legal word is a full-depth reverse
   // behind the longest sender gap and the longest receiver stall;
   // about 600 such words fit well inside this with margin to spare.
   localparam int CYCLE_LIMIT  = 250000;
   // Cycles to idle after the last response; longer than the longest reverse.
   localparam int SETTLE_WAIT  = 40;
   localparam int DRAIN_LIMIT  = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   bounded_lifo_stack_engine_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   // Shadow copy of the stack, advanced once per accepted request word.
   logic signed [31:0] stack_mem [STACK_DEPTH];
   int                 stack_fill;

   // Responses predicted but not yet seen, oldest first.
   rsp_type            awaited_rsp [$];

   int                 mismatch_count;
   int                 cycle_count = 0;
   bit                 req_idle_on;
   bit                 rsp_idle_on;

   // Clock: 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_lifo_stack_engine_top_tb NOT OK");
         $finish;
      end
   end

   // Receiver side: stall the response channel in random bursts while
   // enabled. Each falling edge gets at most one assignment.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Compute the response for one request word and advance the shadow stack.
   function automatic rsp_type apply_stack_op(input req_type w);
      rsp_type            r;
      int                 lo;
      int                 hi;
      logic signed [31:0] swap_word;
      r = '0;
      case (w.kind)
         KIND_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               r.error     = 1'b1;
               r.out_value = ERR_VALUE;
            end else begin
               stack_mem[stack_fill] = w.push_value;
               stack_fill++;
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (stack_fill == 0) begin
               r.error     = 1'b1;
               r.out_value = ERR_VALUE;
            end else begin
               r.out_value = stack_mem[stack_fill - 1];
               if (w.kind == KIND_POP)
                  stack_fill--;
            end
         end
         KIND_CLEAR: begin
            stack_fill = 0;
         end
         KIND_REVERSE: begin
            // Swap end for end; zero or one entry leaves the stack alone.
            lo = 0;
            hi = stack_fill - 1;
            while (lo < hi) begin
               swap_word     = stack_mem[lo];
               stack_mem[lo] = stack_mem[hi];
               stack_mem[hi] = swap_word;
               lo++;
               hi--;
            end
         end
         default: ;
      endcase
      r.is_empty = (stack_fill == 0);
      r.is_full  = (stack_fill >= STACK_DEPTH);
      r.count    = 5'(stack_fill);
      return r;
   endfunction

   // Present one request word at the falling edge, optionally after a random
   // gap, and hold it until the block takes it. Valid is left high after the
   // handshake so back-to-back words never drop it for a step.
   task automatic send_word(input logic [2:0] kind, input logic signed [31:0] value);
      req_type w;
      w.kind       = kind;
      w.push_value = value;
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      awaited_rsp.push_back(apply_stack_op(w));
   endtask

   // Check each response taken at a rising edge against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected response %p", rsp_word));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_word.out_value !== want.out_value)
               report_mismatch($sformatf("out_value got %0d want %0d",
                                         rsp_word.out_value, want.out_value));
            if (rsp_word.error !== want.error)
               report_mismatch($sformatf("error got %b want %b",
                                         rsp_word.error, want.error));
            if (rsp_word.is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty got %b want %b",
                                         rsp_word.is_empty, want.is_empty));
            if (rsp_word.is_full !== want.is_full)
               report_mismatch($sformatf("is_full got %b want %b",
                                         rsp_word.is_full, want.is_full));
            if (rsp_word.count !== want.count)
               report_mismatch($sformatf("count got %0d want %0d",
                                         rsp_word.count, want.count));
         end
      end
   end

   // Draw a push value: mostly random bits, now and then an extreme.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Draw a kind. In fill mode pushes dominate so the stack reaches full;
   // in drain mode pops dominate so it reaches empty. A few words are noise.
   function automatic logic [2:0] pick_kind(input bit fill_mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)  return KIND_CLEAR;
      if (roll < 10) return KIND_REVERSE;
      if (roll < 18) return KIND_PEEK;
      if (roll < 22) begin
         case ($urandom_range(0, 2))
            0:       return KIND_SPARE_LO;
            1:       return KIND_SPARE_MID;
            default: return KIND_SPARE_HI;
         endcase
      end
      if (fill_mode)
         return (roll < 80) ? KIND_PUSH : KIND_POP;
      return (roll < 40) ? KIND_PUSH : KIND_POP;
   endfunction

   // Errors on an empty stack, the no-op codes, and reverse of zero and one
   // entry.
   task automatic test_empty_stack();
      send_word(KIND_POP, pick_value());
      send_word(KIND_PEEK, pick_value());
      send_word(KIND_REVERSE, pick_value());
      send_word(KIND_CLEAR, pick_value());
      send_word(KIND_SPARE_LO, pick_value());
      send_word(KIND_SPARE_MID, pick_value());
      send_word(KIND_SPARE_HI, pick_value());
      send_word(KIND_PUSH, 32'sh80000000);
      send_word(KIND_REVERSE, pick_value());
      send_word(KIND_POP, pick_value());
   endtask

   // Fill to the brim, starting with extreme words, overflow once, reverse
   // a full stack, then read back and clear.
   task automatic test_fill_and_overflow();
      send_word(KIND_PUSH, 32'sh7fffffff);
      send_word(KIND_PUSH, 32'sh80000000);
      send_word(KIND_PUSH, 32'sh55555555);
      send_word(KIND_PUSH, 32'shaaaaaaaa);
      send_word(KIND_PUSH, -32'sd1);
      send_word(KIND_PUSH, 32'sd0);
      for (int i = 6; i < STACK_DEPTH; i++)
         send_word(KIND_PUSH, $urandom);
      send_word(KIND_PUSH, pick_value());
      send_word(KIND_REVERSE, pick_value());
      send_word(KIND_PEEK, pick_value());
      send_word(KIND_POP, pick_value());
      send_word(KIND_CLEAR, pick_value());
   endtask

   // Random push/pop runs that swing between full and empty. Undecoded kinds
   // are sent but not counted toward the total.
   task automatic test_random_mix(input int total);
      int         counted;
      int         run_left;
      bit         fill_mode;
      logic [2:0] kind;
      counted  = 0;
      run_left = 0;
      fill_mode = 1'b1;
      while (counted < total) begin
         if (run_left == 0) begin
            fill_mode = ~fill_mode;
            run_left  = $urandom_range(10, 40);
         end
         run_left--;
         kind = pick_kind(fill_mode);
         send_word(kind, pick_value());
         if (kind <= KIND_REVERSE)
            counted++;
      end
   endtask

   initial begin
      int drain_cycles;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      stack_fill     = 0;
      mismatch_count = 0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_fill_and_overflow();
      test_random_mix(400);

      // Finish with full-rate traffic on both sides.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_mix(100);

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the outstanding responses, then settle.
      drain_cycles = 0;
      while (awaited_rsp.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (awaited_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));
      repeat (SETTLE_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("bounded_lifo_stack_engine_top_tb OK");
      else
         $display("bounded_lifo_stack_engine_top_tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/blse_pkg.sv
rtl/bounded_lifo_stack_engine_top.sv
dv/bounded_lifo_stack_engine_top_tb.sv
